>>> rtl/core/usbbd_pkg.sv
`timescale 1ns / 1ps

package usbbd_pkg;

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT  = 2'd1;
    localparam logic [1:0] ST_OVERSIZE   = 2'd2;
    localparam logic [1:0] ST_BAD_HEADER = 2'd3;

    localparam logic [7:0] HDR_FLAGS  = 8'hc0;
    localparam logic [3:0] ID_NIBBLE  = 4'hf;
    localparam int         HEADER_LEN = 2;

    localparam logic [6:0] MPS_RESET = 7'd64;
    localparam logic [6:0] PKT_SAT   = 7'd127;

    localparam int ADDR_W    = 3;
    localparam logic REG_MPS = 1'b0;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // one record per accepted input transaction that gives any result
    typedef struct packed {
        logic        has_pay;
        logic        has_end;
        logic [7:0]  payload_byte;
        logic [11:0] message_id;
        logic [1:0]  status;
    } rec_t;

    typedef struct packed {
        logic              q_valid;
        logic              q_ready;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    typedef struct packed {
        logic end_pend;
    } back_stat_t;

endpackage

>>> rtl/core/usbbd_front.sv
`timescale 1ns / 1ps

module usbbd_front #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                packet_end,
    input  logic [6:0]          max_packet_size,
    output logic                push,
    output usbbd_pkg::rec_t     rec
);

    localparam int TB_W = $clog2(BUFFER_BYTES);
    localparam logic [TB_W-1:0] TB_LIMIT = TB_W'(BUFFER_BYTES - 2);

    logic [TB_W-1:0] tb_reg, tb_next;
    logic [6:0]      pkt_reg, pkt_next;
    logic [7:0]      hl_reg, hl_next;
    logic [7:0]      hh_reg, hh_next;
    logic            ovs_reg, ovs_next;

    logic [TB_W-1:0] tb_mid;
    logic [6:0]      pkt_mid;
    logic [7:0]      hl_mid, hh_mid;
    logic            ovs_mid;
    logic            pay;
    logic            fin;
    logic [11:0]     id;
    logic [1:0]      st;

    always_comb begin
        tb_mid  = tb_reg;
        pkt_mid = pkt_reg;
        hl_mid  = hl_reg;
        hh_mid  = hh_reg;
        ovs_mid = ovs_reg;
        pay     = 1'b0;
        if (has_byte) begin
            if (pkt_reg != usbbd_pkg::PKT_SAT) begin
                pkt_mid = pkt_reg + 7'd1;
            end
            if (!ovs_reg) begin
                if (tb_reg >= TB_LIMIT) begin
                    ovs_mid = 1'b1;
                end else begin
                    tb_mid = tb_reg + TB_W'(1);
                    if (tb_mid == TB_W'(1)) begin
                        hl_mid = data_byte;
                    end else if (tb_mid == TB_W'(2)) begin
                        hh_mid = data_byte;
                    end else begin
                        pay = 1'b1;
                    end
                end
            end
        end

        fin = packet_end && (pkt_mid != max_packet_size);
        id  = {hh_mid[3:0] & usbbd_pkg::ID_NIBBLE, hl_mid};

        if (ovs_mid) begin
            st = usbbd_pkg::ST_OVERSIZE;
        end else if (tb_mid < TB_W'(usbbd_pkg::HEADER_LEN)) begin
            st = usbbd_pkg::ST_TOO_SHORT;
        end else if ((hh_mid & usbbd_pkg::HDR_FLAGS) != usbbd_pkg::HDR_FLAGS) begin
            st = usbbd_pkg::ST_BAD_HEADER;
        end else begin
            st = usbbd_pkg::ST_ACCEPTED;
        end

        tb_next  = tb_mid;
        pkt_next = pkt_mid;
        hl_next  = hl_mid;
        hh_next  = hh_mid;
        ovs_next = ovs_mid;
        if (packet_end) begin
            if (fin) begin
                tb_next  = '0;
                pkt_next = '0;
                hl_next  = '0;
                hh_next  = '0;
                ovs_next = 1'b0;
            end else begin
                pkt_next = '0;
            end
        end
    end

    assign push             = accept && (pay || fin);
    assign rec.has_pay      = pay;
    assign rec.has_end      = fin;
    assign rec.payload_byte = data_byte;
    // id reads as zero until both header bytes are in
    assign rec.message_id   = (tb_mid < TB_W'(usbbd_pkg::HEADER_LEN)) ? 12'd0 : id;
    assign rec.status       = st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg  <= '0;
            pkt_reg <= '0;
            hl_reg  <= '0;
            hh_reg  <= '0;
            ovs_reg <= 1'b0;
        end else if (accept) begin
            tb_reg  <= tb_next;
            pkt_reg <= pkt_next;
            hl_reg  <= hl_next;
            hh_reg  <= hh_next;
            ovs_reg <= ovs_next;
        end
    end

endmodule

>>> rtl/core/usbbd_queue.sv
`timescale 1ns / 1ps

module usbbd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  usbbd_pkg::rec_t        push_rec,
    input  logic                   pop,
    output usbbd_pkg::rec_t        pop_rec,
    output usbbd_pkg::queue_stat_t stat
);

    usbbd_pkg::rec_t mem_reg [usbbd_pkg::QDEPTH];

    logic [usbbd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [usbbd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [usbbd_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                         do_push, do_pop;

    assign stat.q_valid = (cnt_reg != '0);
    assign stat.q_ready = (cnt_reg != usbbd_pkg::QCNT_W'(usbbd_pkg::QDEPTH));
    assign stat.count   = cnt_reg;
    assign do_push      = push && stat.q_ready;
    assign do_pop       = pop && stat.q_valid;
    assign pop_rec      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/usbbd_back.sv
`timescale 1ns / 1ps

module usbbd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  usbbd_pkg::rec_t       q_rec,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_payload_byte,
    output logic [11:0]           m_message_id,
    output logic [1:0]            m_status,
    output logic                  m_last,
    output usbbd_pkg::back_stat_t stat
);

    logic        m_valid_reg;
    logic [7:0]  byte_reg;
    logic [11:0] id_reg;
    logic [1:0]  st_reg;
    logic        last_reg;
    logic        pend_reg;
    logic [11:0] pend_id_reg;
    logic [1:0]  pend_st_reg;
    logic        load;

    assign load  = !m_valid_reg || m_ready;
    assign q_pop = load && !pend_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= 1'b0;
            end else if (q_valid) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= q_rec.has_pay && q_rec.has_end;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                byte_reg <= 8'd0;
                id_reg   <= pend_id_reg;
                st_reg   <= pend_st_reg;
                last_reg <= 1'b1;
            end else if (q_valid) begin
                pend_id_reg <= q_rec.message_id;
                pend_st_reg <= q_rec.status;
                id_reg      <= q_rec.message_id;
                if (q_rec.has_pay) begin
                    byte_reg <= q_rec.payload_byte;
                    st_reg   <= usbbd_pkg::ST_ACCEPTED;
                    last_reg <= 1'b0;
                end else begin
                    byte_reg <= 8'd0;
                    st_reg   <= q_rec.status;
                    last_reg <= 1'b1;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = byte_reg;
    assign m_message_id   = id_reg;
    assign m_status       = st_reg;
    assign m_last         = last_reg;
    assign stat.end_pend  = pend_reg;

endmodule

>>> rtl/core/usb_bulk_message_deframer_unit.sv
`timescale 1ns / 1ps
// a transaction's first result goes through the record queue, then the output register
// throughput: one input transaction per cycle while the queue has room; a payload
// and status transaction gives two outputs, absorbed by a four-entry record queue
// reset: synchronous active-low aresetn clears counters, header, queue and output valid
// max_packet_size returns to 64

module usb_bulk_message_deframer_unit #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_data_byte,
    input  logic                         s_has_byte,
    input  logic                         s_packet_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_payload_byte,
    output logic [11:0]                  m_message_id,
    output logic [1:0]                   m_status,
    output logic                         m_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [usbbd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [6:0]             mps_reg;
    logic                   accept;
    logic                   push;
    logic                   q_pop;
    usbbd_pkg::rec_t        push_rec;
    usbbd_pkg::rec_t        pop_rec;
    usbbd_pkg::queue_stat_t q_stat;
    usbbd_pkg::back_stat_t  b_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == usbbd_pkg::REG_MPS) ? {25'd0, mps_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mps_reg <= usbbd_pkg::MPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == usbbd_pkg::REG_MPS) begin
            mps_reg <= pwdata[6:0];
        end
    end

    assign s_ready = q_stat.q_ready;
    assign accept  = s_valid && s_ready;

    usbbd_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_data_byte),
        .has_byte        (s_has_byte),
        .packet_end      (s_packet_end),
        .max_packet_size (mps_reg),
        .push            (push),
        .rec             (push_rec)
    );

    usbbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .stat     (q_stat)
    );

    usbbd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_stat.q_valid),
        .q_rec          (pop_rec),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_message_id   (m_message_id),
        .m_status       (m_status),
        .m_last         (m_last),
        .stat           (b_stat)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= usbbd_pkg::QCNT_W'(usbbd_pkg::QDEPTH))
        else $error("record queue overfilled");

    a_pend_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.end_pend |-> (m_valid && !m_last))
        else $error("pending status without a payload byte on show");

    a_pend_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_stat.end_pend && m_ready) |=> (m_valid && m_last))
        else $error("pending status not issued next");

    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == usbbd_pkg::ST_ACCEPTED))
        else $error("payload transaction carries a status");

endmodule
